@@ hw/rtl/brush_dynamics_curve_eval_unit_assert.svh @@
// Assertion macros shared by the curve evaluator RTL
`ifndef BRUSH_DYNAMICS_CURVE_EVAL_UNIT_ASSERT_SVH
`define BRUSH_DYNAMICS_CURVE_EVAL_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BDCE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BDCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDCE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define BDCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/bdce_pkg.sv @@
// Types and constants for the brush dynamics curve evaluator
package bdce_pkg;

  localparam int unsigned CURVE_POINTS_DEFAULT = 256;

  localparam int unsigned T_W      = 17;  // Q1.16 value, 65536 is one
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SRC_W    = 24;  // Q16.8 velocity / distance
  localparam int unsigned QUO_W    = 16;
  localparam int unsigned DIV_STEP = 2;   // quotient bits per stage
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEP;
  localparam int unsigned PROD_W   = 49;  // 32 x 17 range product

  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0]  DYN_MODE_RST     = 2'd1;
  localparam logic [31:0] RANGE_MIN_RST    = 32'd0;
  localparam logic [31:0] RANGE_MAX_RST    = 32'd65536;
  localparam logic [23:0] VEL_LIMIT_RST    = 24'd256;
  localparam logic [23:0] DIST_LIMIT_RST   = 24'd256;
  localparam logic [1:0]  OUT_MODE_RST     = 2'd2;
  localparam logic [15:0] SIZE_LIMIT_RST   = 16'd1000;

  typedef enum logic [2:0] {
    CFG_DYNAMIC_MODE   = 3'd0,
    CFG_RANGE_MIN      = 3'd1,
    CFG_RANGE_MAX      = 3'd2,
    CFG_VELOCITY_LIMIT = 3'd3,
    CFG_DISTANCE_LIMIT = 3'd4,
    CFG_OUTPUT_MODE    = 3'd5,
    CFG_SIZE_LIMIT     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DYN_NONE     = 2'd0,
    DYN_PRESSURE = 2'd1,
    DYN_VELOCITY = 2'd2,
    DYN_DISTANCE = 2'd3
  } dyn_mode_e;

  typedef enum logic [1:0] {
    OUT_SOFT  = 2'd0,
    OUT_PIXEL = 2'd1,
    OUT_BYTE  = 2'd2
  } out_mode_e;

  // one stage of the normalizing divider and everything riding along
  typedef struct packed {
    logic             valid;
    logic             wr;
    logic             bypass;
    logic             use_div;
    logic [T_W-1:0]   t;
    logic [SRC_W-1:0] rem;
    logic [SRC_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic [7:0]       cidx;
    logic [T_W-1:0]   cval;
  } div_stage_t;

endpackage

@@ hw/rtl/bdce_ram.sv @@
// Generic RAM: one write port, two registered read ports
module bdce_ram
  import bdce_pkg::*;
#(
  parameter int unsigned WIDTH = T_W,
  parameter int unsigned DEPTH = CURVE_POINTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hw/rtl/brush_dynamics_curve_eval_unit.sv @@
// Brush dynamics curve evaluator: normalize, curve interpolate, scale, round
//
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_stall_o    action, pressure, velocity, distance,
//                                          curve_index, curve_value
// out      out  out_valid_o / out_stall_i  param_value, scaled_value
// cfg      in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while the pipeline is not held. A result passes through the
// entry register, the quotient pipeline that retires two bits per stage, and stages A, R,
// I, J, K, L and the output register. Curve writes take the same path and update the table
// at the read stage, so they stay in order with evaluations; they give no result.
// Reset clears control and config; the curve table is not cleared.
// The whole pipeline holds while the output register is full and stalled.
`include "brush_dynamics_curve_eval_unit_assert.svh"

module brush_dynamics_curve_eval_unit
  import bdce_pkg::*;
#(
  parameter int unsigned CURVE_POINTS = CURVE_POINTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [16:0] pressure_i,
  input  logic [23:0] velocity_i,
  input  logic [23:0] distance_i,
  input  logic [7:0]  curve_index_i,
  input  logic [16:0] curve_value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] param_value_o,
  output logic [23:0] scaled_value_o
);

  localparam int unsigned AW = $clog2(CURVE_POINTS);
  localparam int unsigned PW = T_W + AW;
  localparam logic [AW-1:0] LAST_IDX = AW'(CURVE_POINTS - 1);

  // configuration registers
  dyn_mode_e   dynamic_mode_q;
  logic [31:0] range_min_q;
  logic [31:0] range_max_q;
  logic [23:0] velocity_limit_q;
  logic [23:0] distance_limit_q;
  logic [1:0]  output_mode_q;
  logic [15:0] size_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dynamic_mode_q   <= dyn_mode_e'(DYN_MODE_RST);
      range_min_q      <= RANGE_MIN_RST;
      range_max_q      <= RANGE_MAX_RST;
      velocity_limit_q <= VEL_LIMIT_RST;
      distance_limit_q <= DIST_LIMIT_RST;
      output_mode_q    <= OUT_MODE_RST;
      size_limit_q     <= SIZE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DYNAMIC_MODE:   dynamic_mode_q   <= dyn_mode_e'(cfg_wdata_i[1:0]);
        CFG_RANGE_MIN:      range_min_q      <= cfg_wdata_i;
        CFG_RANGE_MAX:      range_max_q      <= cfg_wdata_i;
        CFG_VELOCITY_LIMIT: velocity_limit_q <= cfg_wdata_i[23:0];
        CFG_DISTANCE_LIMIT: distance_limit_q <= cfg_wdata_i[23:0];
        CFG_OUTPUT_MODE:    output_mode_q    <= cfg_wdata_i[1:0];
        CFG_SIZE_LIMIT:     size_limit_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves unless the output is held
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // entry selection
  logic [SRC_W-1:0] ent_num;
  logic [SRC_W-1:0] ent_den;
  logic             ent_sat;
  logic             ent_bypass;
  logic             ent_use_div;
  logic [T_W-1:0]   ent_t;

  always_comb begin
    ent_num = (dynamic_mode_q == DYN_VELOCITY) ? velocity_i : distance_i;
    ent_den = (dynamic_mode_q == DYN_VELOCITY) ? velocity_limit_q : distance_limit_q;
    ent_sat = ent_num >= ent_den;  // also covers a zero limit
    ent_bypass = (dynamic_mode_q == DYN_NONE) || (range_min_q >= range_max_q);
    ent_use_div = !action_i && !ent_sat &&
                  ((dynamic_mode_q == DYN_VELOCITY) || (dynamic_mode_q == DYN_DISTANCE));
    if (dynamic_mode_q == DYN_PRESSURE) begin
      ent_t = (pressure_i > ONE_Q16) ? ONE_Q16 : pressure_i;
    end else begin
      ent_t = ONE_Q16;
    end
  end

  // entry register and restoring divider stages: quo = (num << 16) / den
  div_stage_t div_q [0:DIV_STAGES];
  div_stage_t div_d [0:DIV_STAGES];

  always_comb begin
    logic [SRC_W:0] r2;
    r2 = '0;
    div_d[0].valid   = in_valid_i;
    div_d[0].wr      = action_i;
    div_d[0].bypass  = ent_bypass;
    div_d[0].use_div = ent_use_div;
    div_d[0].t       = ent_t;
    div_d[0].rem     = ent_num;
    div_d[0].den     = ent_den;
    div_d[0].quo     = '0;
    div_d[0].cidx    = curve_index_i;
    div_d[0].cval    = curve_value_i;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      div_d[k] = div_q[k-1];
      for (int s = 0; s < DIV_STEP; s++) begin
        r2 = {div_d[k].rem, 1'b0};
        if (r2 >= {1'b0, div_d[k].den}) begin
          div_d[k].rem = SRC_W'(r2 - {1'b0, div_d[k].den});
          div_d[k].quo = {div_d[k].quo[QUO_W-2:0], 1'b1};
        end else begin
          div_d[k].rem = r2[SRC_W-1:0];
          div_d[k].quo = {div_d[k].quo[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_q[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // stage A: curve position t * (N - 1)
  logic [T_W-1:0] a_t;
  logic [PW-1:0]  a_pos_d;
  logic           a_valid_q;
  logic           a_wr_q;
  logic           a_bypass_q;
  logic [PW-1:0]  a_pos_q;
  logic [7:0]     a_cidx_q;
  logic [T_W-1:0] a_cval_q;

  assign a_t = div_q[DIV_STAGES].use_div ? {1'b0, div_q[DIV_STAGES].quo}
                                         : div_q[DIV_STAGES].t;
  assign a_pos_d = PW'(a_t) * PW'(LAST_IDX);

  // stage R: table addresses, curve write, registered table read
  logic [AW:0]       a_idx;
  logic              a_last;
  logic [AW-1:0]     ram_addr_a;
  logic [AW-1:0]     ram_addr_b;
  logic              ram_we;
  logic [T_W-1:0]    ram_rdata_a;
  logic [T_W-1:0]    ram_rdata_b;
  logic [FRAC_W-1:0] r_frac_d;
  logic              r_valid_q;
  logic              r_bypass_q;
  logic [FRAC_W-1:0] r_frac_q;

  assign a_idx      = a_pos_q[PW-1:FRAC_W];
  assign a_last     = a_idx >= {1'b0, LAST_IDX};
  assign ram_addr_a = a_last ? LAST_IDX : a_idx[AW-1:0];
  assign ram_addr_b = a_last ? LAST_IDX : a_idx[AW-1:0] + AW'(1);
  assign r_frac_d   = a_last ? '0 : a_pos_q[FRAC_W-1:0];
  assign ram_we     = adv && a_valid_q && a_wr_q && ({24'd0, a_cidx_q} < CURVE_POINTS);

  bdce_ram #(
    .WIDTH (T_W),
    .DEPTH (CURVE_POINTS)
  ) u_curve_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (AW'(a_cidx_q)),
    .wdata_i   (a_cval_q),
    .re_i      (adv),
    .raddr_a_i (ram_addr_a),
    .raddr_b_i (ram_addr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // stage I: (b - a) * frac
  logic signed [T_W:0]   i_diff;
  logic signed [34:0]    i_prod_d;
  logic                  i_valid_q;
  logic                  i_bypass_q;
  logic signed [34:0]    i_prod_q;
  logic [T_W-1:0]        i_a_q;

  assign i_diff   = $signed({1'b0, ram_rdata_b}) - $signed({1'b0, ram_rdata_a});
  assign i_prod_d = i_diff * $signed({1'b0, r_frac_q});

  // stage J: p = a + round((b - a) * frac / 65536), floor semantics
  logic signed [35:0] j_rnd;
  logic signed [35:0] j_sum;
  logic [T_W-1:0]     j_p_d;
  logic               j_valid_q;
  logic               j_bypass_q;
  logic [T_W-1:0]     j_p_q;

  assign j_rnd = (36'(i_prod_q) + 36'sd32768) >>> FRAC_W;
  assign j_sum = j_rnd + $signed({19'd0, i_a_q});
  assign j_p_d = j_sum[T_W-1:0];

  // stage K: (max - min) * p
  logic [31:0]       k_span;
  logic [PROD_W-1:0] k_prod_d;
  logic              k_valid_q;
  logic              k_bypass_q;
  logic [PROD_W-1:0] k_prod_q;

  assign k_span   = range_max_q - range_min_q;
  assign k_prod_d = PROD_W'(k_span) * PROD_W'(j_p_q);

  // stage L: param = min + rounded product, saturated; bypass gives max
  logic [33:0] l_sum;
  logic [31:0] l_param_d;
  logic        l_valid_q;
  logic [31:0] l_param_q;

  assign l_sum = 34'(range_min_q) + 34'((k_prod_q + PROD_W'(32768)) >> FRAC_W);
  assign l_param_d = k_bypass_q ? range_max_q
                   : ((|l_sum[33:32]) ? 32'hFFFF_FFFF : l_sum[31:0]);

  // output stage: rounding per output mode and clamp
  logic [40:0] o_full;
  logic [23:0] o_lim;
  logic [23:0] o_scaled_d;
  logic [31:0] out_param_q;
  logic [23:0] out_scaled_q;

  always_comb begin
    case (output_mode_q)
      OUT_SOFT: begin
        o_full = 41'((34'(l_param_q) + 34'd128) >> 8);
        o_lim  = {size_limit_q, 8'd0};
      end
      OUT_PIXEL: begin
        o_full = 41'((34'(l_param_q) + 34'd32768) >> FRAC_W);
        o_lim  = 24'(size_limit_q);
      end
      default: begin
        // x255 as x256 minus one
        o_full = (41'({l_param_q, 8'd0}) - 41'(l_param_q) + 41'd32768) >> FRAC_W;
        o_lim  = 24'd255;
      end
    endcase
    o_scaled_d = (o_full > 41'(o_lim)) ? o_lim : o_full[23:0];
  end

  // valid bits of the post-divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      r_valid_q   <= 1'b0;
      i_valid_q   <= 1'b0;
      j_valid_q   <= 1'b0;
      k_valid_q   <= 1'b0;
      l_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= div_q[DIV_STAGES].valid;
      r_valid_q   <= a_valid_q && !a_wr_q;  // curve writes end here
      i_valid_q   <= r_valid_q;
      j_valid_q   <= i_valid_q;
      k_valid_q   <= j_valid_q;
      l_valid_q   <= k_valid_q;
      out_valid_q <= l_valid_q;
    end
  end

  // payload of the post-divider stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_wr_q       <= div_q[DIV_STAGES].wr;
      a_bypass_q   <= div_q[DIV_STAGES].bypass;
      a_pos_q      <= a_pos_d;
      a_cidx_q     <= div_q[DIV_STAGES].cidx;
      a_cval_q     <= div_q[DIV_STAGES].cval;
      r_bypass_q   <= a_bypass_q;
      r_frac_q     <= r_frac_d;
      i_bypass_q   <= r_bypass_q;
      i_prod_q     <= i_prod_d;
      i_a_q        <= ram_rdata_a;
      j_bypass_q   <= i_bypass_q;
      j_p_q        <= j_p_d;
      k_bypass_q   <= j_bypass_q;
      k_prod_q     <= k_prod_d;
      l_param_q    <= l_param_d;
      out_param_q  <= l_param_q;
      out_scaled_q <= o_scaled_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign param_value_o  = out_param_q;
  assign scaled_value_o = out_scaled_q;

  `BDCE_ASSERT_IMPL(a_div_rem_bound, clk_i, rst_ni, div_q[DIV_STAGES].valid && div_q[DIV_STAGES].use_div, div_q[DIV_STAGES].rem < div_q[DIV_STAGES].den, "divider remainder not below limit")
  `BDCE_ASSERT_IMPL(a_curve_idx_bound, clk_i, rst_ni, a_valid_q, a_idx <= {1'b0, LAST_IDX}, "curve index past last point")
  `BDCE_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, !adv, $stable({a_valid_q, r_valid_q, l_valid_q, out_valid_q}), "pipeline moved while held")

endmodule

@@ test/tb_brush_dynamics_curve_eval_unit.sv @@
// Self-checking testbench for brush_dynamics_curve_eval_unit
`timescale 1ns / 1ps

module tb_brush_dynamics_curve_eval_unit;
  import bdce_pkg::*;

  localparam int unsigned NUM_POINTS  = CURVE_POINTS_DEFAULT;
  localparam int unsigned LATENCY     = DIV_STAGES + 7;
  localparam int unsigned QUIET       = LATENCY + 8;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 52;
  // output_mode code with no enum member; must behave like OUT_BYTE
  localparam logic [1:0]  OUT_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [31:0] param;
    logic [23:0] scaled;
  } brush_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [16:0] pressure_i;
  logic [23:0] velocity_i;
  logic [23:0] distance_i;
  logic [7:0]  curve_index_i;
  logic [16:0] curve_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] param_value_o;
  logic [23:0] scaled_value_o;

  brush_dynamics_curve_eval_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .pressure_i     (pressure_i),
    .velocity_i     (velocity_i),
    .distance_i     (distance_i),
    .curve_index_i  (curve_index_i),
    .curve_value_i  (curve_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .param_value_o  (param_value_o),
    .scaled_value_o (scaled_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the block's registers and curve table
  dyn_mode_e   dyn_src;
  logic [31:0] range_lo;
  logic [31:0] range_hi;
  logic [23:0] vel_limit;
  logic [23:0] dist_limit;
  logic [1:0]  out_form;
  logic [15:0] size_cap;
  logic [16:0] curve_shadow [NUM_POINTS];

  brush_result_t pending_params[$];
  int unsigned   mismatches = 0;
  int unsigned   burst_left = 0;

  function automatic longint unsigned norm_q16(input longint unsigned src,
                                               input longint unsigned limit);
    if (src < limit) return (src << 16) / limit;
    return 64'd65536;
  endfunction

  function automatic brush_result_t brush_param_of(input logic [16:0] pressure,
                                                   input logic [23:0] velocity,
                                                   input logic [23:0] distance);
    longint unsigned t, pos, idx, frac, a, b, p, lo, hi, param, scaled, cap;
    brush_result_t   r;
    lo = 64'(range_lo);
    hi = 64'(range_hi);
    if (dyn_src == DYN_NONE || lo >= hi) begin
      param = hi;
    end else begin
      case (dyn_src)
        DYN_PRESSURE: t = 64'((pressure > ONE_Q16) ? ONE_Q16 : pressure);
        DYN_VELOCITY: t = norm_q16(64'(velocity), 64'(vel_limit));
        default:      t = norm_q16(64'(distance), 64'(dist_limit));
      endcase
      pos  = t * (NUM_POINTS - 1);
      idx  = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= NUM_POINTS - 1) begin
        p = 64'(curve_shadow[NUM_POINTS-1]);
      end else begin
        a = 64'(curve_shadow[idx]);
        b = 64'(curve_shadow[idx+1]);
        p = (a * (64'd65536 - frac) + b * frac + 64'd32768) >> 16;
      end
      param = lo + (((hi - lo) * p + 64'd32768) >> 16);
      if (param > 64'hFFFF_FFFF) param = 64'hFFFF_FFFF;
    end
    if (out_form == OUT_SOFT) begin
      scaled = (param + 64'd128) >> 8;
      cap    = 64'(size_cap) * 64'd256;
    end else if (out_form == OUT_PIXEL) begin
      scaled = (param + 64'd32768) >> 16;
      cap    = 64'(size_cap);
    end else begin
      scaled = (param * 64'd255 + 64'd32768) >> 16;
      cap    = 64'd255;
    end
    if (scaled > cap) scaled = cap;
    r.param  = param[31:0];
    r.scaled = scaled[23:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // one input transaction; the sender runs in bursts with random gaps
  task automatic send_item(input logic act, input logic [16:0] pres,
                           input logic [23:0] vel, input logic [23:0] dst,
                           input logic [7:0] cidx, input logic [16:0] cval);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    pressure_i    <= pres;
    velocity_i    <= vel;
    distance_i    <= dst;
    curve_index_i <= cidx;
    curve_value_i <= cval;
    do @(posedge clk_i); while (in_stall_o);
    if (act) curve_shadow[cidx] = cval;
    else pending_params.push_back(brush_param_of(pres, vel, dst));
  endtask

  task automatic eval_sample(input logic [16:0] pres, input logic [23:0] vel,
                             input logic [23:0] dst);
    send_item(1'b0, pres, vel, dst, 8'($urandom), 17'($urandom));
  endtask

  task automatic write_point(input logic [7:0] cidx, input logic [16:0] cval);
    send_item(1'b1, 17'($urandom), 24'($urandom), 24'($urandom), cidx, cval);
  endtask

  task automatic idle_bus();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // hold the sender until every result is back and the pipeline is empty
  task automatic wait_results_done();
    idle_bus();
    while (pending_params.size() != 0) @(posedge clk_i);
    repeat (QUIET) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_DYNAMIC_MODE:   dyn_src    = dyn_mode_e'(data[1:0]);
      CFG_RANGE_MIN:      range_lo   = data;
      CFG_RANGE_MAX:      range_hi   = data;
      CFG_VELOCITY_LIMIT: vel_limit  = data[23:0];
      CFG_DISTANCE_LIMIT: dist_limit = data[23:0];
      CFG_OUTPUT_MODE:    out_form   = data[1:0];
      default:            size_cap   = data[15:0];
    endcase
  endtask

  // receiver stall pattern: switches between free, light, heavy and long runs
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned run_left   = 0;
  logic        run_stall  = 1'b0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      mode_left  = $urandom_range(32, 200);
      stall_mode = $urandom_range(0, 3);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_stall = !run_stall;
          run_left  = run_stall ? $urandom_range(1, 30) : $urandom_range(1, 10);
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    endcase
  end

  // ---------------------------------------------------------------- checker

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
  endtask

  brush_result_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_params.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected, expected none actual 0x%0h/0x%0h",
                   $time, param_value_o, scaled_value_o);
      end else begin
        want_res = pending_params.pop_front();
        if (param_value_o !== want_res.param)
          flag_mismatch("param_value", 64'(want_res.param), 64'(param_value_o));
        if (scaled_value_o !== want_res.scaled)
          flag_mismatch("scaled_value", 64'(want_res.scaled), 64'(scaled_value_o));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [23:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom_range(1, 256));
      3:       return 24'd256;
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [23:0] pick_sample(input logic [23:0] limit);
    case ($urandom_range(0, 7))
      0:       return 24'($urandom);
      1:       return limit;
      2:       return 24'hFFFFFF;
      3:       return 24'd0;
      default: return (limit == 0) ? 24'($urandom) : 24'($urandom_range(0, limit - 1));
    endcase
  endfunction

  function automatic logic [16:0] pick_pressure();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return ONE_Q16;
      2:       return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic randomize_config();
    logic [31:0] a, b, lo, hi;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 5))
      0: begin lo = 32'd0; hi = 32'hFFFF_FFFF; end
      1: begin lo = a; hi = a; end
      2: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
      3: begin
        lo = $urandom_range(0, 32'h0004_0000);
        hi = lo + $urandom_range(1, 32'h0040_0000);
      end
      default: begin lo = (a > b) ? b : a; hi = (a > b) ? a : b; end
    endcase
    cfg_write(CFG_DYNAMIC_MODE, ($urandom_range(0, 7) == 0) ? 32'(DYN_NONE)
                                                            : $urandom_range(1, 3));
    cfg_write(CFG_RANGE_MIN, lo);
    cfg_write(CFG_RANGE_MAX, hi);
    cfg_write(CFG_VELOCITY_LIMIT, 32'(pick_limit()));
    cfg_write(CFG_DISTANCE_LIMIT, 32'(pick_limit()));
    cfg_write(CFG_OUTPUT_MODE, $urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0:       cfg_write(CFG_SIZE_LIMIT, 32'd0);
      1:       cfg_write(CFG_SIZE_LIMIT, 32'd65535);
      2:       cfg_write(CFG_SIZE_LIMIT, 32'd1);
      default: cfg_write(CFG_SIZE_LIMIT, $urandom_range(0, 4000));
    endcase
  endtask

  // every entry is written before any sample can read it
  task automatic test_curve_load();
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (i == 0)                       write_point(8'(i), 17'd0);
      else if (i == NUM_POINTS - 1)     write_point(8'(i), ONE_Q16);
      else if ($urandom_range(0, 7) == 0) write_point(8'(i), ONE_Q16);
      else                              write_point(8'(i), 17'($urandom_range(0, 65536)));
    end
    wait_results_done();
  endtask

  // pressure source, byte output, as left by reset; includes pressure above one
  task automatic test_reset_defaults();
    eval_sample(17'd0, 24'd0, 24'd0);
    eval_sample(17'd257, 24'd0, 24'd0);
    eval_sample(17'd32768, 24'd0, 24'd0);
    eval_sample(17'd65535, 24'd0, 24'd0);
    eval_sample(ONE_Q16, 24'd0, 24'd0);
    eval_sample(17'd65537, 24'd0, 24'd0);
    eval_sample(17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF);
    wait_results_done();
  endtask

  // velocity and distance normalization: below, at and above the limit, zero limit
  task automatic test_sources();
    cfg_write(CFG_DYNAMIC_MODE, 32'(DYN_VELOCITY));
    cfg_write(CFG_VELOCITY_LIMIT, 32'd1000);
    eval_sample(17'd0, 24'd0, 24'd0);
    eval_sample(17'd0, 24'd999, 24'd0);
    eval_sample(17'd0, 24'd1000, 24'd0);
    eval_sample(17'd0, 24'hFFFFFF, 24'd0);
    wait_results_done();
    cfg_write(CFG_VELOCITY_LIMIT, 32'd0);
    eval_sample(17'd0, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_DYNAMIC_MODE, 32'(DYN_DISTANCE));
    cfg_write(CFG_DISTANCE_LIMIT, 32'h00FF_FFFF);
    eval_sample(17'd0, 24'd0, 24'd0);
    eval_sample(17'd0, 24'd0, 24'hFFFFFE);
    eval_sample(17'd0, 24'd0, 24'hFFFFFF);
    wait_results_done();
  endtask

  // no dynamic, empty ranges, full range and every output form with its clamp
  task automatic test_ranges_and_forms();
    cfg_write(CFG_DYNAMIC_MODE, 32'(DYN_NONE));
    cfg_write(CFG_RANGE_MIN, 32'd100);
    cfg_write(CFG_RANGE_MAX, 32'h0005_0000);
    eval_sample(17'd40000, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_DYNAMIC_MODE, 32'(DYN_PRESSURE));
    cfg_write(CFG_RANGE_MIN, 32'h0003_0000);
    cfg_write(CFG_RANGE_MAX, 32'h0003_0000);
    eval_sample(17'd40000, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_RANGE_MIN, 32'hFFFF_FFFF);
    eval_sample(17'd40000, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_RANGE_MIN, 32'd0);
    cfg_write(CFG_RANGE_MAX, 32'hFFFF_FFFF);
    cfg_write(CFG_OUTPUT_MODE, 32'(OUT_SOFT));
    cfg_write(CFG_SIZE_LIMIT, 32'd0);
    eval_sample(ONE_Q16, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_SIZE_LIMIT, 32'd65535);
    eval_sample(ONE_Q16, 24'd0, 24'd0);
    eval_sample(17'd30000, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_OUTPUT_MODE, 32'(OUT_PIXEL));
    eval_sample(ONE_Q16, 24'd0, 24'd0);
    eval_sample(17'd12345, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_OUTPUT_MODE, 32'(OUT_UNDEFINED));
    eval_sample(17'd40000, 24'd0, 24'd0);
    wait_results_done();
    cfg_write(CFG_OUTPUT_MODE, 32'(OUT_BYTE));
    eval_sample(ONE_Q16, 24'd0, 24'd0);
    wait_results_done();
  endtask

  // random settings per phase; mostly samples, some table rewrites
  task automatic test_random();
    for (int ph = 0; ph < PHASES; ph++) begin
      randomize_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 15) == 0) write_point(8'($urandom), 17'($urandom));
          else write_point(8'($urandom), 17'($urandom_range(0, 65536)));
        end else begin
          eval_sample(pick_pressure(), pick_sample(vel_limit), pick_sample(dist_limit));
        end
        // in every fourth phase the sender holds off mid-phase until the block has drained
        if (ph % 4 == 1 && n == PHASE_ITEMS / 2) wait_results_done();
      end
      wait_results_done();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DYNAMIC_MODE;
    cfg_wdata_i   = 32'd0;
    in_valid_i    = 1'b0;
    action_i      = 1'b0;
    pressure_i    = 17'd0;
    velocity_i    = 24'd0;
    distance_i    = 24'd0;
    curve_index_i = 8'd0;
    curve_value_i = 17'd0;
    out_stall_i   = 1'b0;
    dyn_src       = dyn_mode_e'(DYN_MODE_RST);
    range_lo      = RANGE_MIN_RST;
    range_hi      = RANGE_MAX_RST;
    vel_limit     = VEL_LIMIT_RST;
    dist_limit    = DIST_LIMIT_RST;
    out_form      = OUT_MODE_RST;
    size_cap      = SIZE_LIMIT_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_curve_load();
    test_reset_defaults();
    test_sources();
    test_ranges_and_forms();
    test_random();
    wait_results_done();

    if (mismatches == 0 && pending_params.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
